/* hdl/sfls_pkg.sv */
// Shared types, codes and helpers for the serial frame link sequencer.
`timescale 1ns / 1ps

package sfls_pkg;

  localparam int FRAME_MAX = 32;
  localparam int IDX_W     = 5;    // buffer index width
  localparam int LEN_W     = 6;    // frame length register width
  localparam int TICK_W    = 8;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // event kinds
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_TXRDY = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_RX_LEN     = 2'd0;
  localparam logic [1:0] REG_TX_LEN     = 2'd1;
  localparam logic [1:0] REG_TURNAROUND = 2'd2;
  localparam logic [1:0] REG_TIMEOUT    = 2'd3;

  localparam logic [LEN_W-1:0]  RX_LEN_RST     = 6'd20;
  localparam logic [LEN_W-1:0]  TX_LEN_RST     = 6'd16;
  localparam logic [TICK_W-1:0] TURNAROUND_RST = 8'd10;
  localparam logic [TICK_W-1:0] TIMEOUT_RST    = 8'd220;

  typedef enum logic [2:0] {
    PH_RX_STANDBY  = 3'd0,
    PH_RX_ACTIVE   = 3'd1,
    PH_RX_COMPLETE = 3'd2,
    PH_TX_STANDBY  = 3'd3,
    PH_TX_ACTIVE   = 3'd4,
    PH_TX_COMPLETE = 3'd5,
    PH_TEST        = 3'd6,
    PH_COMPUTE     = 3'd7
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic             rx_store_valid;
    logic [IDX_W-1:0] rx_store_index;
    logic [7:0]       rx_store_byte;
    logic             send_valid;
    logic [IDX_W-1:0] send_index;
    logic             load_tx_strobe;
    logic             frame_done_strobe;
    logic             test_strobe;
    logic             compute_strobe;
    logic             byte_gap_error;
    logic             packet_timeout;
    logic             extra_byte;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  rx_frame_len;
    logic [LEN_W-1:0]  tx_frame_len;
    logic [TICK_W-1:0] turnaround_ticks;
    logic [TICK_W-1:0] packet_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic gap;
    logic timeout;
    logic extra;
  } flags_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(FRAME_MAX)) ? LEN_W'(FRAME_MAX) : len;
  endfunction

endpackage

/* hdl/sfls_regs.sv */
// APB configuration registers of the link sequencer.
`timescale 1ns / 1ps

module sfls_regs import sfls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t        cfg_q, cfg_d;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_RX_LEN:     cfg_d.rx_frame_len         = pwdata[LEN_W-1:0];
        REG_TX_LEN:     cfg_d.tx_frame_len         = pwdata[LEN_W-1:0];
        REG_TURNAROUND: cfg_d.turnaround_ticks     = pwdata[TICK_W-1:0];
        REG_TIMEOUT:    cfg_d.packet_timeout_ticks = pwdata[TICK_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RX_LEN:     prdata = DATA_W'(cfg_q.rx_frame_len);
      REG_TX_LEN:     prdata = DATA_W'(cfg_q.tx_frame_len);
      REG_TURNAROUND: prdata = DATA_W'(cfg_q.turnaround_ticks);
      REG_TIMEOUT:    prdata = DATA_W'(cfg_q.packet_timeout_ticks);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rx_frame_len         <= RX_LEN_RST;
      cfg_q.tx_frame_len         <= TX_LEN_RST;
      cfg_q.turnaround_ticks     <= TURNAROUND_RST;
      cfg_q.packet_timeout_ticks <= TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/sfls_core.sv */
// Link state registers and the per-event update logic.
`timescale 1ns / 1ps

module sfls_core import sfls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  phase_e            phase_q, phase_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [TICK_W-1:0] lbt_q, lbt_d;
  logic [IDX_W-1:0]  rx_pos_q, rx_pos_d;
  logic [IDX_W-1:0]  tx_pos_q, tx_pos_d;
  logic [TICK_W-1:0] wait_q, wait_d;
  flags_t            flags_q, flags_d;

  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] wait_inc;
  logic [LEN_W-1:0]  rx_pos_inc;
  logic [LEN_W-1:0]  tx_pos_inc;
  logic [LEN_W-1:0]  rx_len;
  logic [LEN_W-1:0]  tx_len;
  logic              gap;

  assign tick_inc   = tick_q + 8'd1;
  assign wait_inc   = wait_q + 8'd1;
  assign rx_pos_inc = {1'b0, rx_pos_q} + 6'd1;
  assign tx_pos_inc = {1'b0, tx_pos_q} + 6'd1;
  assign rx_len     = clamp_len(cfg_i.rx_frame_len);
  assign tx_len     = clamp_len(cfg_i.tx_frame_len);
  // no gap when the byte comes in the same tick or the next one (no wrap)
  assign gap = !((tick_q == lbt_q) ||
                 ({1'b0, tick_q} == ({1'b0, lbt_q} + 9'd1)));

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    lbt_d    = lbt_q;
    rx_pos_d = rx_pos_q;
    tx_pos_d = tx_pos_q;
    wait_d   = wait_q;
    flags_d  = flags_q;
    res_o    = '0;

    case (item_i.mode)
      MODE_TICK: begin
        tick_d = tick_inc;
        if (tick_inc > cfg_i.packet_timeout_ticks) begin
          tick_d          = '0;
          flags_d.timeout = 1'b1;
        end
        case (phase_q)
          PH_RX_COMPLETE: begin
            phase_d              = PH_TX_STANDBY;
            wait_d               = wait_inc;
            res_o.load_tx_strobe = 1'b1;
          end
          PH_TX_STANDBY: begin
            wait_d = wait_inc;
            if (wait_inc >= cfg_i.turnaround_ticks) begin
              wait_d           = '0;
              phase_d          = PH_TX_ACTIVE;
              tx_pos_d         = '0;
              res_o.send_valid = 1'b1;
            end
          end
          PH_TX_COMPLETE: begin
            tick_d                  = '0;
            phase_d                 = PH_TEST;
            res_o.frame_done_strobe = 1'b1;
          end
          PH_TEST: begin
            phase_d           = PH_COMPUTE;
            res_o.test_strobe = 1'b1;
          end
          PH_COMPUTE: begin
            phase_d              = PH_RX_STANDBY;
            flags_d              = '0;
            res_o.compute_strobe = 1'b1;
          end
          default: ;
        endcase
      end
      MODE_BYTE: begin
        if (phase_q == PH_RX_STANDBY || phase_q == PH_RX_ACTIVE) begin
          lbt_d = tick_q;
          if (gap && rx_pos_q != '0) begin
            // gap inside a frame: drop byte, restart frame
            flags_d.gap = 1'b1;
            rx_pos_d    = '0;
            phase_d     = PH_RX_STANDBY;
            lbt_d       = '0;
          end else begin
            if (gap) begin
              phase_d = PH_RX_ACTIVE;
            end
            res_o.rx_store_valid = 1'b1;
            res_o.rx_store_index = rx_pos_q;
            res_o.rx_store_byte  = item_i.rx_byte;
            rx_pos_d             = rx_pos_inc[IDX_W-1:0];
            if (rx_pos_inc >= rx_len) begin
              rx_pos_d = '0;
              phase_d  = PH_RX_COMPLETE;
              lbt_d    = '0;
            end
          end
        end else begin
          flags_d.extra = 1'b1;
        end
      end
      MODE_TXRDY: begin
        if (phase_q == PH_TX_ACTIVE) begin
          tx_pos_d = tx_pos_inc[IDX_W-1:0];
          if (tx_pos_inc < tx_len) begin
            res_o.send_valid = 1'b1;
            res_o.send_index = tx_pos_inc[IDX_W-1:0];
          end else begin
            phase_d = PH_TX_COMPLETE;
          end
        end
      end
      default: ;
    endcase

    res_o.byte_gap_error = flags_d.gap;
    res_o.packet_timeout = flags_d.timeout;
    res_o.extra_byte     = flags_d.extra;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_RX_STANDBY;
      tick_q   <= '0;
      lbt_q    <= '0;
      rx_pos_q <= '0;
      tx_pos_q <= '0;
      wait_q   <= '0;
      flags_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      lbt_q    <= lbt_d;
      rx_pos_q <= rx_pos_d;
      tx_pos_q <= tx_pos_d;
      wait_q   <= wait_d;
      flags_q  <= flags_d;
    end
  end

  // at most one request or strobe per event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> $onehot0({res_o.rx_store_valid, res_o.send_valid, res_o.load_tx_strobe,
                         res_o.frame_done_strobe, res_o.test_strobe,
                         res_o.compute_strobe}))
    else $error("sfls_core: more than one action in one event");

  // compute strobe reports cleared flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.compute_strobe) |=> (flags_q == '0))
    else $error("sfls_core: flags not cleared by compute");

  // test phase always moves on to compute on a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.mode == MODE_TICK && phase_q == PH_TEST) |=>
      (phase_q == PH_COMPUTE))
    else $error("sfls_core: test phase did not advance");

  // tick counter never rests above the timeout limit after a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.mode == MODE_TICK && $stable(cfg_i)) |=>
      (tick_q <= cfg_i.packet_timeout_ticks))
    else $error("sfls_core: tick counter above timeout");

endmodule

/* hdl/serial_frame_link_sequencer_unit.sv */
// Top level of the serial frame link sequencer: handshake stages and config port.
`timescale 1ns / 1ps

// Polled half-duplex link controller.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries events: a tick, a
// received byte or a transmitter-ready. Every event gives exactly one result
// transfer on the output channel (out_valid_o/out_ready_i/out_data_o) holding
// the frame-buffer store request, the send request, the load/done/test/compute
// strobes and the three sticky flags as they stand after the event.
// An accepted event sits in the input register, is processed when it moves
// into the result register and its result is offered from then on.
// Throughput: one event per cycle while results are taken; the state update
// is a single short compare/increment step between the input register and
// the result register. When the receiver stalls, the result register holds
// and the input register still takes one more event; in_ready_o drops only
// when both are full.
// Reset (rst_ni low, asynchronous) puts the link in receive standby, clears
// counters and flags, empties both stages and loads the register defaults
// (rx length 20, tx length 16, turnaround 10, timeout 220).
// APB registers at 0x0 rx_frame_len, 0x4 tx_frame_len, 0x8 turnaround_ticks,
// 0xC packet_timeout_ticks; write them only while the block is idle.

module serial_frame_link_sequencer_unit import sfls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q, in_vld_d;
  out_item_t out_q;
  out_item_t res;
  logic      out_vld_q, out_vld_d;
  logic      in_xfer;
  logic      step;    // input register moves into the result register

  sfls_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfls_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result slot is free when empty or being taken this cycle
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign in_vld_d  = in_xfer || (in_vld_q && !step);
  assign out_vld_d = step || (out_vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // a stalled result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> (out_vld_q && $stable(out_q)))
    else $error("sequencer: stalled result changed");

  // every accepted event is held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_vld_q)
    else $error("sequencer: accepted event lost");

  // input stage only blocks while both stages are full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("sequencer: input stalled without cause");

endmodule

/* tb/sfls_link_checker.sv */
// Checker: predicts every result of the link sequencer and compares it field by field.
`timescale 1ns / 1ps

module sfls_link_checker import sfls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ev_valid_i,
  input  logic              ev_ready_i,
  input  in_item_t          ev_i,
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  out_item_t         res_i,
  input  logic              apb_psel_i,
  input  logic              apb_penable_i,
  input  logic              apb_pwrite_i,
  input  logic              apb_pready_i,
  input  logic [ADDR_W-1:0] apb_paddr_i,
  input  logic [DATA_W-1:0] apb_pwdata_i,
  output int                mismatches_o,
  output int                outstanding_o
);

  // shadow of the block's registers and link state
  cfg_t       cfg;
  phase_e     ph;
  logic [7:0] tick_cnt;
  logic [7:0] last_rx_tick;
  logic [7:0] turn_cnt;
  int         rx_idx;
  int         tx_idx;
  flags_t     flg;

  out_item_t  pending_results[$];
  out_item_t  want;
  int         n_bad;

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
    n_bad         = 0;
  end

  function automatic out_item_t advance_link(in_item_t ev);
    out_item_t r;
    logic      gap;
    logic      dropped;
    int        rx_lim;
    int        tx_lim;
    r      = '0;
    rx_lim = (cfg.rx_frame_len > FRAME_MAX) ? FRAME_MAX : int'(cfg.rx_frame_len);
    tx_lim = (cfg.tx_frame_len > FRAME_MAX) ? FRAME_MAX : int'(cfg.tx_frame_len);
    case (ev.mode)
      MODE_TICK: begin
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt > cfg.packet_timeout_ticks) begin
          tick_cnt    = '0;
          flg.timeout = 1'b1;
        end
        case (ph)
          PH_RX_COMPLETE: begin
            ph               = PH_TX_STANDBY;
            turn_cnt         = turn_cnt + 8'd1;
            r.load_tx_strobe = 1'b1;
          end
          PH_TX_STANDBY: begin
            turn_cnt = turn_cnt + 8'd1;
            if (turn_cnt >= cfg.turnaround_ticks) begin
              turn_cnt     = '0;
              ph           = PH_TX_ACTIVE;
              tx_idx       = 0;
              r.send_valid = 1'b1;
              r.send_index = '0;
            end
          end
          PH_TX_COMPLETE: begin
            tick_cnt            = '0;
            r.frame_done_strobe = 1'b1;
            ph                  = PH_TEST;
          end
          PH_TEST: begin
            r.test_strobe = 1'b1;
            ph            = PH_COMPUTE;
          end
          PH_COMPUTE: begin
            r.compute_strobe = 1'b1;
            ph               = PH_RX_STANDBY;
            flg              = '0;
          end
          default: ;
        endcase
      end
      MODE_BYTE: begin
        if (ph == PH_RX_STANDBY || ph == PH_RX_ACTIVE) begin
          // no gap when the byte lands on the same tick or the one after
          gap = !((tick_cnt == last_rx_tick) ||
                  (int'(tick_cnt) == int'(last_rx_tick) + 1));
          dropped      = 1'b0;
          last_rx_tick = tick_cnt;
          if (gap) begin
            if (rx_idx > 0) begin
              flg.gap      = 1'b1;
              rx_idx       = 0;
              ph           = PH_RX_STANDBY;
              last_rx_tick = '0;
              dropped      = 1'b1;
            end else begin
              rx_idx = 0;
              ph     = PH_RX_ACTIVE;
            end
          end
          if (!dropped) begin
            r.rx_store_valid = 1'b1;
            r.rx_store_index = IDX_W'(rx_idx);
            r.rx_store_byte  = ev.rx_byte;
            rx_idx++;
            if (rx_idx >= rx_lim) begin
              rx_idx       = 0;
              ph           = PH_RX_COMPLETE;
              last_rx_tick = '0;
            end
          end
        end else begin
          flg.extra = 1'b1;
        end
      end
      MODE_TXRDY: begin
        if (ph == PH_TX_ACTIVE) begin
          tx_idx++;
          if (tx_idx < tx_lim) begin
            r.send_valid = 1'b1;
            r.send_index = IDX_W'(tx_idx);
          end else begin
            ph = PH_TX_COMPLETE;
          end
        end
      end
      default: ;
    endcase
    r.byte_gap_error = flg.gap;
    r.packet_timeout = flg.timeout;
    r.extra_byte     = flg.extra;
    return r;
  endfunction

  task automatic check_field(input string what, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      n_bad++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.rx_frame_len         = RX_LEN_RST;
      cfg.tx_frame_len         = TX_LEN_RST;
      cfg.turnaround_ticks     = TURNAROUND_RST;
      cfg.packet_timeout_ticks = TIMEOUT_RST;
      ph           = PH_RX_STANDBY;
      tick_cnt     = '0;
      last_rx_tick = '0;
      turn_cnt     = '0;
      rx_idx       = 0;
      tx_idx       = 0;
      flg          = '0;
      pending_results.delete();
      outstanding_o <= 0;
    end else begin
      if (apb_psel_i && apb_penable_i && apb_pwrite_i && apb_pready_i) begin
        case (apb_paddr_i[3:2])
          REG_RX_LEN:     cfg.rx_frame_len         = apb_pwdata_i[LEN_W-1:0];
          REG_TX_LEN:     cfg.tx_frame_len         = apb_pwdata_i[LEN_W-1:0];
          REG_TURNAROUND: cfg.turnaround_ticks     = apb_pwdata_i[TICK_W-1:0];
          REG_TIMEOUT:    cfg.packet_timeout_ticks = apb_pwdata_i[TICK_W-1:0];
          default: ;
        endcase
      end
      // retire before predicting: a result never belongs to an event of the same edge
      if (res_valid_i && res_ready_i) begin
        if (pending_results.size() == 0) begin
          n_bad++;
          $display("%0t: result with nothing expected, expected none, actual %h",
                   $time, res_i);
        end else begin
          want = pending_results.pop_front();
          check_field("rx_store_valid", want.rx_store_valid, res_i.rx_store_valid);
          check_field("rx_store_index", want.rx_store_index, res_i.rx_store_index);
          check_field("rx_store_byte", want.rx_store_byte, res_i.rx_store_byte);
          check_field("send_valid", want.send_valid, res_i.send_valid);
          check_field("send_index", want.send_index, res_i.send_index);
          check_field("load_tx_strobe", want.load_tx_strobe, res_i.load_tx_strobe);
          check_field("frame_done_strobe", want.frame_done_strobe, res_i.frame_done_strobe);
          check_field("test_strobe", want.test_strobe, res_i.test_strobe);
          check_field("compute_strobe", want.compute_strobe, res_i.compute_strobe);
          check_field("byte_gap_error", want.byte_gap_error, res_i.byte_gap_error);
          check_field("packet_timeout", want.packet_timeout, res_i.packet_timeout);
          check_field("extra_byte", want.extra_byte, res_i.extra_byte);
        end
      end
      if (ev_valid_i && ev_ready_i)
        pending_results.push_back(advance_link(ev_i));
      outstanding_o <= pending_results.size();
      mismatches_o  <= n_bad;
    end
  end

endmodule

/* tb/tb_serial_frame_link_sequencer_unit.sv */
// Testbench top for the link sequencer: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module tb_serial_frame_link_sequencer_unit;
  import sfls_pkg::*;

  localparam logic [1:0] MODE_RSVD = 2'd3;  // unused event code, block must ignore it
  localparam int WATCHDOG_LIMIT = 4000;     // cycles without any transfer
  localparam int LONG_HOLD      = 80;       // receiver hold-off, fills both stages
  localparam int SETTLE         = 6;        // pipeline is two deep, leave some margin

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int outstanding;

  // stimulus bookkeeping
  int n_sent;           // counted per phase, ignored event codes left out
  bit snd_burst = 1'b0; // sender runs back to back while set
  bit rcv_burst = 1'b0; // receiver never stalls while set
  bit hold_rcv  = 1'b0; // asks the receiver for one long hold-off

  serial_frame_link_sequencer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  sfls_link_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ev_valid_i    (in_valid),
    .ev_ready_i    (in_ready),
    .ev_i          (in_data),
    .res_valid_i   (out_valid),
    .res_ready_i   (out_ready),
    .res_i         (out_data),
    .apb_psel_i    (psel),
    .apb_penable_i (penable),
    .apb_pwrite_i  (pwrite),
    .apb_pready_i  (pready),
    .apb_paddr_i   (paddr),
    .apb_pwdata_i  (pwdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Bail out if neither channel moves a transfer for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stall before each transfer, burst stretches without
  // stalls, and one long hold-off on request so the input side backs up.
  initial begin : result_sink
    int stall;
    forever begin
      if (hold_rcv) begin
        hold_rcv = 1'b0;
        stall    = LONG_HOLD;
      end else if (rcv_burst) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 7);
      end
      if ($urandom_range(0, 49) == 0) rcv_burst = !rcv_burst;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // One APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one event after a random gap and return right after its transfer.
  // With no gap, valid just stays high and only the payload changes.
  task automatic send_event(input logic [1:0] kind, input logic [7:0] data);
    in_item_t it;
    int       gap;
    it.mode    = kind;
    it.rx_byte = data;
    if ($urandom_range(0, 39) == 0) snd_burst = !snd_burst;
    gap = snd_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    if (kind != MODE_RSVD) n_sent++;
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // A well-formed exchange with random content: receive frame (at most one
  // tick between bytes, now and then a two-tick gap to break it), turnaround
  // ticks, one transmitter-ready per tx byte, then done/test/compute ticks.
  task automatic run_exchange(input cfg_t c);
    int n_rx;
    int n_tx;
    int pick;
    n_rx = (c.rx_frame_len > FRAME_MAX) ? FRAME_MAX : int'(c.rx_frame_len);
    n_tx = (c.tx_frame_len > FRAME_MAX) ? FRAME_MAX : int'(c.tx_frame_len);
    if (n_rx == 0) n_rx = 1;
    if (n_tx == 0) n_tx = 1;
    for (int i = 0; i < n_rx; i++) begin
      if (i > 0) begin
        pick = $urandom_range(0, 24);
        if (pick == 0)
          repeat (2) send_event(MODE_TICK, 8'($urandom_range(0, 255)));
        else if (pick < 10)
          send_event(MODE_TICK, 8'($urandom_range(0, 255)));
      end
      send_event(MODE_BYTE, 8'($urandom_range(0, 255)));
    end
    repeat (int'(c.turnaround_ticks) + 1) send_event(MODE_TICK, 8'($urandom_range(0, 255)));
    repeat (n_tx) send_event(MODE_TXRDY, 8'($urandom_range(0, 255)));
    repeat (3) send_event(MODE_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Unstructured events, all four codes.
  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // Program all registers (block is idle here), run random traffic, drain.
  task automatic run_phase(input cfg_t c, input int budget, input bit long_hold);
    write_reg(REG_RX_LEN, DATA_W'(c.rx_frame_len));
    write_reg(REG_TX_LEN, DATA_W'(c.tx_frame_len));
    write_reg(REG_TURNAROUND, DATA_W'(c.turnaround_ticks));
    write_reg(REG_TIMEOUT, DATA_W'(c.packet_timeout_ticks));
    n_sent = 0;
    while (n_sent < budget) begin
      if (long_hold && n_sent > 30) begin
        hold_rcv  = 1'b1;
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 4) != 0) run_exchange(c);
      else send_noise();
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: two-byte rx frame, one-byte tx frame, shortest turnaround.
    write_reg(REG_RX_LEN, DATA_W'(2));
    write_reg(REG_TX_LEN, DATA_W'(1));
    write_reg(REG_TURNAROUND, DATA_W'(1));
    send_event(MODE_TICK, 8'h00);
    send_event(MODE_TXRDY, 8'h00);  // not transmitting: ignored
    send_event(MODE_RSVD, 8'hFF);   // unused code: ignored, flags still reported
    send_event(MODE_BYTE, 8'h00);   // first byte, stored at 0
    send_event(MODE_TICK, 8'hFF);
    send_event(MODE_TICK, 8'h00);
    send_event(MODE_BYTE, 8'hFF);   // gap in mid-frame: dropped, gap flag
    send_event(MODE_BYTE, 8'h80);   // gap at frame start: restarts the frame
    send_event(MODE_BYTE, 8'h7F);   // completes the frame
    send_event(MODE_BYTE, 8'h55);   // outside receive: extra-byte flag
    send_event(MODE_TICK, 8'h00);   // load strobe
    send_event(MODE_TICK, 8'h00);   // turnaround reached, byte 0 sent
    send_event(MODE_BYTE, 8'hAA);   // extra byte while transmitting
    send_event(MODE_TXRDY, 8'h00);  // last tx byte done
    send_event(MODE_TICK, 8'h00);   // frame done
    send_event(MODE_TICK, 8'h00);   // test
    send_event(MODE_TICK, 8'h00);   // compute, flags cleared
    send_event(MODE_RSVD, 8'h00);
    drain();

    // Random phases; each one ends with the sender waiting for every result.
    run_phase(cfg_t'{6'd20, 6'd16, 8'd10,  8'd220}, 300, 1'b1);
    run_phase(cfg_t'{6'd1,  6'd1,  8'd1,   8'd1},   250, 1'b0);
    run_phase(cfg_t'{6'd32, 6'd32, 8'd3,   8'd254}, 300, 1'b0);
    // long turnaround: one exchange is already about 270 events
    run_phase(cfg_t'{6'd3,  6'd2,  8'd255, 8'd254}, 100, 1'b0);
    // zero lengths, zero turnaround and zero timeout
    run_phase(cfg_t'{6'd0,  6'd0,  8'd0,   8'd0},   250, 1'b0);
    // lengths above the buffer size are clamped; timeout 255 never fires
    run_phase(cfg_t'{6'd63, 6'd40, 8'd0,   8'd255}, 300, 1'b0);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* serial_frame_link_sequencer_unit.f */
hdl/sfls_pkg.sv
hdl/sfls_regs.sv
hdl/sfls_core.sv
hdl/serial_frame_link_sequencer_unit.sv
tb/sfls_link_checker.sv
tb/tb_serial_frame_link_sequencer_unit.sv
